/* src/binary_max_heap_priority_queue_assert.svh */
// assertion macros shared by the heap queue rtl
`ifndef BINARY_MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define BINARY_MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define HPQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define HPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/hpq_pkg.sv */
package hpq_pkg;

  // key and result field widths
  localparam int KEY_W      = 32;
  localparam int CNT_OUT_W  = 11;
  localparam int OUT_DATA_W = 48;

  // operation codes carried on in_tuser
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef logic signed [KEY_W-1:0] key_t;

  // operand steering for the shared key comparator
  typedef struct packed {
    logic key_first;  // compare key against read data (sift-up)
    logic vs_pick;    // compare read data against the current pick
  } cmp_ctl_t;

endpackage

/* src/binary_max_heap_priority_queue.sv */
// channel | ports                         | payload
// input   | in_tvalid in_tready in_tdata  | key_value, in_tuser = kind (0 push, 1 pop)
// result  | out_tvalid out_tready out_tdata | max_key, is_empty, entry_count, op_error
//
// one item at a time; in_tready is high only while the sequencer is idle
// push: read the parent, compare, move it down while the key is larger, then write the key
// pop: read the last entry, then per level read both children, pick the larger, move it up,
// and finally write the key; the steps are serialised by the single memory read port
// errors and single-entry pops skip the memory; a push into an empty heap writes the key directly
// reset clears the state, the count and the output valid only; a stalled result holds the block until taken
module binary_max_heap_priority_queue
  import hpq_pkg::*;
#(
  parameter int HEAP_DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [KEY_W-1:0]      in_tdata,   // [31:0] key_value
  input  logic                  in_tuser,   // [0] kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [31:0] max_key, [32] is_empty,
                                            // [43:33] entry_count, [44] op_error
);

`include "binary_max_heap_priority_queue_assert.svh"

  localparam int IDX_W = $clog2(HEAP_DEPTH);
  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int CH_W  = IDX_W + 2;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_UP_RD   = 9'b000000010,
    ST_UP_CMP  = 9'b000000100,
    ST_POP_RD  = 9'b000001000,
    ST_POP_KEY = 9'b000010000,
    ST_DN_RD_L = 9'b000100000,
    ST_DN_RD_R = 9'b001000000,
    ST_DN_CMP  = 9'b010000000,
    ST_WR_KEY  = 9'b100000000
  } state_t;

  // final state reuses idle encoding space through its own flag
  state_t            state_r, state_nxt;
  logic              fin_r, fin_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [IDX_W-1:0]  pick_idx_r, pick_idx_nxt;
  key_t              key_r, key_nxt;
  key_t              pick_val_r, pick_val_nxt;
  key_t              root_r;
  logic              err_r, err_nxt;

  logic              out_tvalid_r;
  key_t              out_max_r;
  logic              out_empty_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic              out_err_r;
  logic              out_load;

  // key memory
  key_t              heap_mem [HEAP_DEPTH];
  key_t              rd_data_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  key_t              mem_wd;
  logic [IDX_W-1:0]  mem_ra;

  // shared comparator
  cmp_ctl_t          cmp_ctl;
  logic              cmp_gt;
  key_t              cmp_larger;

  // child and parent indices
  logic [CH_W-1:0]   cnt_ext;
  logic [CH_W-1:0]   lc_w, rc_w, lc_pick_w;
  logic [IDX_W-1:0]  parent;
  logic              lc_ok, rc_ok, take_r;
  logic [IDX_W-1:0]  fin_idx;
  key_t              fin_val;
  logic              in_acc;

  assign in_acc    = in_tvalid && in_tready;
  assign cnt_ext   = CH_W'(cnt_r);
  assign lc_w      = {1'b0, pos_r, 1'b1};
  assign rc_w      = lc_w + CH_W'(1);
  assign parent    = (pos_r - IDX_W'(1)) >> 1;
  assign lc_ok     = lc_w < cnt_ext;
  assign rc_ok     = rc_w < cnt_ext;
  assign take_r    = rc_ok && cmp_gt;
  assign fin_idx   = take_r ? rc_w[IDX_W-1:0] : pick_idx_r;
  assign fin_val   = take_r ? cmp_larger : pick_val_r;
  assign lc_pick_w = {1'b0, fin_idx, 1'b1};

  hpq_cmp u_cmp (
    .ctl      (cmp_ctl),
    .rd_key   (rd_data_r),
    .hold_key (key_r),
    .pick_key (pick_val_r),
    .gt       (cmp_gt),
    .larger   (cmp_larger)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    fin_nxt       = fin_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    pick_idx_nxt  = pick_idx_r;
    key_nxt       = key_r;
    pick_val_nxt  = pick_val_r;
    err_nxt       = err_r;
    mem_we        = 1'b0;
    mem_wa        = pos_r;
    mem_wd        = key_r;
    mem_ra        = lc_w[IDX_W-1:0];
    cmp_ctl       = '0;
    out_load      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (fin_r) begin
          // hand the result over once the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_load = 1'b1;
            fin_nxt  = 1'b0;
          end
        end else if (in_acc) begin
          err_nxt = 1'b0;
          pos_nxt = '0;
          key_nxt = key_t'(in_tdata);
          if (in_tuser == OP_PUSH) begin
            if (cnt_r >= CNT_W'(HEAP_DEPTH)) begin
              err_nxt = 1'b1;
              fin_nxt = 1'b1;
            end else begin
              pos_nxt   = cnt_r[IDX_W-1:0];
              cnt_nxt   = cnt_r + CNT_W'(1);
              state_nxt = (cnt_r == '0) ? ST_WR_KEY : ST_UP_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              err_nxt = 1'b1;
              fin_nxt = 1'b1;
            end else if (cnt_r == CNT_W'(1)) begin
              cnt_nxt = '0;
              fin_nxt = 1'b1;
            end else begin
              cnt_nxt   = cnt_r - CNT_W'(1);
              state_nxt = ST_POP_RD;
            end
          end
        end
      end
      ST_UP_RD: begin
        mem_ra    = parent;
        state_nxt = ST_UP_CMP;
      end
      ST_UP_CMP: begin
        // move the parent down into the hole while the key is larger
        cmp_ctl.key_first = 1'b1;
        if (cmp_gt) begin
          mem_we    = 1'b1;
          mem_wd    = rd_data_r;
          pos_nxt   = parent;
          state_nxt = (parent == '0) ? ST_WR_KEY : ST_UP_RD;
        end else begin
          state_nxt = ST_WR_KEY;
        end
      end
      ST_POP_RD: begin
        // last entry sits at the new count
        mem_ra    = cnt_r[IDX_W-1:0];
        state_nxt = ST_POP_KEY;
      end
      ST_POP_KEY: begin
        key_nxt   = rd_data_r;
        state_nxt = lc_ok ? ST_DN_RD_R : ST_WR_KEY;
      end
      ST_DN_RD_L: begin
        state_nxt = ST_DN_RD_R;
      end
      ST_DN_RD_R: begin
        // left child arrives, right child read issued
        mem_ra = rc_w[IDX_W-1:0];
        if (cmp_gt) begin
          pick_val_nxt = cmp_larger;
          pick_idx_nxt = lc_w[IDX_W-1:0];
        end else begin
          pick_val_nxt = key_r;
          pick_idx_nxt = pos_r;
        end
        state_nxt = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        cmp_ctl.vs_pick = 1'b1;
        if (fin_idx != pos_r) begin
          mem_we    = 1'b1;
          mem_wd    = fin_val;
          pos_nxt   = fin_idx;
          mem_ra    = lc_pick_w[IDX_W-1:0];
          state_nxt = (lc_pick_w < cnt_ext) ? ST_DN_RD_L : ST_WR_KEY;
        end else begin
          state_nxt = ST_WR_KEY;
        end
      end
      ST_WR_KEY: begin
        mem_we    = 1'b1;
        fin_nxt   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fin_r        <= 1'b0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    pick_idx_r <= pick_idx_nxt;
    key_r      <= key_nxt;
    pick_val_r <= pick_val_nxt;
    err_r      <= err_nxt;
    if (mem_we && mem_wa == '0) begin
      root_r <= mem_wd;
    end
    if (out_load) begin
      out_max_r   <= (cnt_r == '0) ? '0 : root_r;
      out_empty_r <= cnt_r == '0;
      out_cnt_r   <= CNT_OUT_W'(cnt_r);
      out_err_r   <= err_r;
    end
  end

  // key memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= heap_mem[mem_ra];
  end

  assign in_tready  = (state_r == ST_IDLE) && !fin_r;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_err_r, out_cnt_r, out_empty_r, out_max_r};

  // checks
  `HPQ_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(HEAP_DEPTH), "entry count above depth")
  `HPQ_ASSERT_NEXT(a_busy_after_beat, in_tvalid && in_tready, !in_tready, "ready right after beat")
  `HPQ_ASSERT_IMPL(a_wr_in_op, mem_we, state_r != ST_IDLE, "key write while idle")
  `HPQ_ASSERT_IMPL(a_empty_zero, out_tvalid_r && out_empty_r, out_max_r == '0, "empty max nonzero")

endmodule

/* src/hpq_cmp.sv */
module hpq_cmp
  import hpq_pkg::*;
(
  input  cmp_ctl_t ctl,
  input  key_t     rd_key,
  input  key_t     hold_key,
  input  key_t     pick_key,
  output logic     gt,
  output key_t     larger
);

  key_t op_a;
  key_t op_b;

  // operand select
  always_comb begin
    if (ctl.key_first) begin
      op_a = hold_key;
      op_b = rd_key;
    end else begin
      op_a = rd_key;
      op_b = ctl.vs_pick ? pick_key : hold_key;
    end
  end

  // strict signed compare, ties keep the second operand
  assign gt     = op_a > op_b;
  assign larger = gt ? op_a : op_b;

endmodule
